### hdl/ubce_pkg.sv
// shared types and constants for the bootloader command engine
`default_nettype none
package ubce_pkg;

    typedef enum logic [3:0] {
        PH_IDLE, PH_CMD2, PH_ADDR, PH_ADDR_X, PH_RCNT, PH_RCNT_X, PH_RFWD,
        PH_ECNT, PH_EX, PH_WCNT, PH_WDATA, PH_WDATA_X
    } t_phase;

    localparam logic [1:0] OP_RX    = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_FLASH = 2'd2;
    localparam logic [1:0] OP_FETCH = 2'd3;

    localparam logic [2:0] K_TX     = 3'd0;
    localparam logic [2:0] K_READ   = 3'd1;
    localparam logic [2:0] K_WRITE  = 3'd2;
    localparam logic [2:0] K_ERASE  = 3'd3;
    localparam logic [2:0] K_NOTICE = 3'd4;
    localparam logic [2:0] K_BUF    = 3'd5;

    // reply jobs issued by the front end and expanded by the back end
    typedef enum logic [3:0] {
        J_NONE, J_ACK, J_NACK, J_BYTE, J_INFO, J_VERSION, J_READ, J_WRITE,
        J_ERASE, J_BUF
    } t_job_kind;

    typedef struct packed {
        t_job_kind   kind;
        logic [7:0]  data;
        logic [31:0] addr;
        logic [8:0]  count;
    } t_job;

    localparam int JobW = $bits(t_job);
    localparam int QueueDepth = 4;
    localparam int BufDepth = 256;

    localparam logic [7:0] C_SYNC   = 8'h7F;
    localparam logic [7:0] C_INFO   = 8'h00;
    localparam logic [7:0] C_VER    = 8'h02;
    localparam logic [7:0] C_READ   = 8'h11;
    localparam logic [7:0] C_ERASE  = 8'h43;
    localparam logic [7:0] C_WRITE  = 8'h31;
    localparam logic [7:0] C_XERASE = 8'h44;
    localparam logic [7:0] C_SPEC   = 8'h50;

    localparam logic [1:0] R_TIMEOUT = 2'd0;
    localparam logic [1:0] R_ACK     = 2'd1;
    localparam logic [1:0] R_NACK    = 2'd2;

    function automatic logic [7:0] info_byte(input logic [3:0] i);
        logic [7:0] v;
        case (i)
            4'd0: v = 8'd11;
            4'd1: v = 8'h10;
            4'd2: v = 8'h00;
            4'd3: v = 8'h01;
            4'd4: v = 8'h02;
            4'd5: v = 8'h11;
            4'd6: v = 8'h21;
            4'd7: v = 8'h31;
            4'd8: v = 8'h43;
            4'd9: v = 8'h63;
            4'd10: v = 8'h73;
            4'd11: v = 8'h82;
            4'd12: v = 8'h92;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] version_byte(input logic [3:0] i);
        logic [7:0] v;
        case (i)
            4'd0: v = 8'h01;
            4'd1: v = 8'h04;
            4'd2: v = 8'h10;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

### hdl/ubce_ram.sv
// generic single port write, registered read ram
`default_nettype none
module ubce_ram #(
    parameter int Width = 8,
    parameter int Depth = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(Depth)-1:0] i_waddr,
    input  wire logic [Width-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(Depth)-1:0] i_raddr,
    output logic      [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

### hdl/ubce_queue.sv
// small job queue between front and back end
`default_nettype none
module ubce_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire ubce_pkg::t_job  i_job,
    output logic                 o_full,
    input  wire logic            i_pop,
    output ubce_pkg::t_job       o_job,
    output logic                 o_empty
);
    localparam int AW = $clog2(ubce_pkg::QueueDepth);

    ubce_pkg::t_job r_q [ubce_pkg::QueueDepth];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(ubce_pkg::QueueDepth));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_q[r_wp] <= i_job;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push && !o_full) r_wp <= r_wp + 1'b1;
            if (i_pop && !o_empty) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(i_push && !o_full) - (AW+1)'(i_pop && !o_empty);
        end
    end
endmodule
`default_nettype wire

### hdl/ubce_front.sv
// front end: frame parser that turns input requests into reply jobs
`default_nettype none
module ubce_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    output logic                 o_full,
    input  wire logic [1:0]      i_opcode,
    input  wire logic [7:0]      i_data_byte,
    input  wire logic [7:0]      i_fetch_index,
    input  wire logic [15:0]     i_timeout_ticks,
    output logic                 o_job_push,
    output ubce_pkg::t_job       o_job,
    input  wire logic            i_job_full,
    input  wire logic            i_fetch_done,
    output logic                 o_buf_we,
    output logic [7:0]           o_buf_waddr,
    output logic [7:0]           o_buf_wdata
);
    ubce_pkg::t_phase r_phase, n_phase;
    logic [7:0]  r_cmd, n_cmd;
    logic [31:0] r_addr, n_addr;
    logic [8:0]  r_cnt, n_cnt;
    logic [7:0]  r_len, n_len;
    logic [7:0]  r_xor, n_xor;
    logic [15:0] r_idle, n_idle;
    logic [8:0]  r_fwd, n_fwd;
    logic [2:0]  r_fetch, n_fetch;
    logic        acc, known;
    logic [15:0] inc;

    // buffer writes wait until every queued fetch has read the buffer
    assign o_full = i_job_full ||
                    ((r_fetch != '0) &&
                     (r_phase inside {ubce_pkg::PH_WDATA, ubce_pkg::PH_RFWD}));
    assign acc    = i_push && !o_full;
    assign known  = (r_cmd == ubce_pkg::C_INFO) || (r_cmd == ubce_pkg::C_VER) ||
                    (r_cmd == ubce_pkg::C_READ) || (r_cmd == ubce_pkg::C_ERASE) ||
                    (r_cmd == ubce_pkg::C_WRITE) || (r_cmd == ubce_pkg::C_XERASE) ||
                    (r_cmd == ubce_pkg::C_SPEC);
    assign inc    = (r_idle == 16'hFFFF) ? r_idle : r_idle + 16'd1;

    always_comb begin
        n_phase = r_phase; n_cmd = r_cmd; n_addr = r_addr; n_cnt = r_cnt;
        n_len = r_len; n_xor = r_xor; n_idle = r_idle; n_fwd = r_fwd;
        o_job = '0;
        o_job.kind = ubce_pkg::J_NONE;
        o_buf_we = 1'b0;
        o_buf_waddr = r_cnt[7:0];
        o_buf_wdata = i_data_byte;
        if (acc) begin
            case (i_opcode)
                ubce_pkg::OP_FETCH: begin
                    o_job.kind = ubce_pkg::J_BUF;
                    o_job.data = i_fetch_index;
                end
                ubce_pkg::OP_TICK: begin
                    if (r_phase == ubce_pkg::PH_IDLE) begin
                        n_idle = '0;
                    end else begin
                        n_idle = inc;
                        if (inc >= i_timeout_ticks) begin
                            if (r_phase == ubce_pkg::PH_CMD2) o_job.kind = ubce_pkg::J_NACK;
                            n_phase = ubce_pkg::PH_IDLE;
                            n_cnt = '0; n_xor = '0; n_idle = '0; n_fwd = '0;
                        end
                    end
                end
                ubce_pkg::OP_FLASH: begin
                    if (r_phase == ubce_pkg::PH_RFWD && r_fwd != '0) begin
                        n_idle = '0;
                        o_buf_we = 1'b1;
                        o_job.kind = ubce_pkg::J_BYTE;
                        o_job.data = i_data_byte;
                        n_cnt = r_cnt + 9'd1;
                        n_fwd = r_fwd - 9'd1;
                        if (r_fwd == 9'd1) begin
                            n_phase = ubce_pkg::PH_IDLE;
                            n_cnt = '0; n_xor = '0; n_fwd = '0;
                        end
                    end
                end
                default: begin
                    n_idle = '0;
                    case (r_phase)
                        ubce_pkg::PH_IDLE: begin
                            if (i_data_byte == ubce_pkg::C_SYNC) begin
                                o_job.kind = ubce_pkg::J_ACK;
                            end else begin
                                n_cmd = i_data_byte;
                                n_phase = ubce_pkg::PH_CMD2;
                            end
                        end
                        ubce_pkg::PH_CMD2: begin
                            n_phase = ubce_pkg::PH_IDLE;
                            n_cnt = '0; n_xor = '0; n_fwd = '0;
                            if (!known || i_data_byte != ~r_cmd) begin
                                o_job.kind = ubce_pkg::J_NACK;
                            end else begin
                                o_job.kind = ubce_pkg::J_ACK;
                                if (r_cmd == ubce_pkg::C_INFO) begin
                                    o_job.kind = ubce_pkg::J_INFO;
                                end else if (r_cmd == ubce_pkg::C_VER) begin
                                    o_job.kind = ubce_pkg::J_VERSION;
                                end else if (r_cmd == ubce_pkg::C_READ ||
                                             r_cmd == ubce_pkg::C_WRITE ||
                                             r_cmd == ubce_pkg::C_SPEC) begin
                                    n_addr = '0;
                                    n_phase = ubce_pkg::PH_ADDR;
                                end else if (r_cmd == ubce_pkg::C_ERASE) begin
                                    n_phase = ubce_pkg::PH_ECNT;
                                end
                            end
                        end
                        ubce_pkg::PH_ADDR: begin
                            n_addr = {r_addr[23:0], i_data_byte};
                            n_xor = r_xor ^ i_data_byte;
                            n_cnt = r_cnt + 9'd1;
                            if (n_cnt >= ((r_cmd == ubce_pkg::C_SPEC) ? 9'd2 : 9'd4)) begin
                                n_phase = ubce_pkg::PH_ADDR_X;
                            end
                        end
                        ubce_pkg::PH_ADDR_X: begin
                            if (r_xor != i_data_byte) begin
                                o_job.kind = ubce_pkg::J_NACK;
                                n_phase = ubce_pkg::PH_IDLE;
                                n_cnt = '0; n_xor = '0; n_fwd = '0;
                            end else begin
                                o_job.kind = ubce_pkg::J_ACK;
                                if (r_cmd == ubce_pkg::C_READ) begin
                                    n_phase = ubce_pkg::PH_RCNT;
                                end else if (r_cmd == ubce_pkg::C_WRITE) begin
                                    n_phase = ubce_pkg::PH_WCNT;
                                end else begin
                                    n_phase = ubce_pkg::PH_IDLE;
                                    n_cnt = '0; n_xor = '0; n_fwd = '0;
                                end
                            end
                        end
                        ubce_pkg::PH_RCNT: begin
                            n_len = i_data_byte;
                            n_phase = ubce_pkg::PH_RCNT_X;
                        end
                        ubce_pkg::PH_RCNT_X: begin
                            if (~r_len != i_data_byte) begin
                                o_job.kind = ubce_pkg::J_NACK;
                                n_phase = ubce_pkg::PH_IDLE;
                                n_cnt = '0; n_xor = '0; n_fwd = '0;
                            end else begin
                                o_job.kind = ubce_pkg::J_READ;
                                o_job.addr = r_addr;
                                o_job.count = {1'b0, r_len} + 9'd1;
                                n_cnt = '0;
                                n_fwd = {1'b0, r_len} + 9'd1;
                                n_phase = ubce_pkg::PH_RFWD;
                            end
                        end
                        ubce_pkg::PH_RFWD: begin
                        end
                        ubce_pkg::PH_ECNT: begin
                            if (i_data_byte == 8'hFF) begin
                                n_phase = ubce_pkg::PH_EX;
                            end else begin
                                o_job.kind = ubce_pkg::J_NACK;
                                n_phase = ubce_pkg::PH_IDLE;
                                n_cnt = '0; n_xor = '0; n_fwd = '0;
                            end
                        end
                        ubce_pkg::PH_EX: begin
                            o_job.kind = ubce_pkg::J_ERASE;
                            n_phase = ubce_pkg::PH_IDLE;
                            n_cnt = '0; n_xor = '0; n_fwd = '0;
                        end
                        ubce_pkg::PH_WCNT: begin
                            n_len = i_data_byte;
                            n_xor = i_data_byte;
                            n_cnt = '0;
                            n_phase = ubce_pkg::PH_WDATA;
                        end
                        ubce_pkg::PH_WDATA: begin
                            o_buf_we = 1'b1;
                            n_xor = r_xor ^ i_data_byte;
                            n_cnt = r_cnt + 9'd1;
                            if (n_cnt >= {1'b0, r_len} + 9'd1) n_phase = ubce_pkg::PH_WDATA_X;
                        end
                        ubce_pkg::PH_WDATA_X: begin
                            if (r_xor != i_data_byte) begin
                                o_job.kind = ubce_pkg::J_NACK;
                            end else begin
                                o_job.kind = ubce_pkg::J_WRITE;
                                o_job.addr = r_addr;
                                o_job.count = {1'b0, r_len} + 9'd1;
                            end
                            n_phase = ubce_pkg::PH_IDLE;
                            n_cnt = '0; n_xor = '0; n_fwd = '0;
                        end
                        default: begin
                            n_phase = ubce_pkg::PH_IDLE;
                            n_cnt = '0; n_xor = '0; n_fwd = '0;
                        end
                    endcase
                end
            endcase
        end
    end

    assign o_job_push = acc && (o_job.kind != ubce_pkg::J_NONE);

    // fetch jobs queued but not yet answered
    assign n_fetch = r_fetch + 3'(o_job_push && (o_job.kind == ubce_pkg::J_BUF))
                     - 3'(i_fetch_done);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= ubce_pkg::PH_IDLE;
            r_cmd <= '0; r_addr <= '0; r_cnt <= '0; r_len <= '0;
            r_xor <= '0; r_idle <= '0; r_fwd <= '0; r_fetch <= '0;
        end else begin
            r_phase <= n_phase;
            r_cmd <= n_cmd; r_addr <= n_addr; r_cnt <= n_cnt; r_len <= n_len;
            r_xor <= n_xor; r_idle <= n_idle; r_fwd <= n_fwd; r_fetch <= n_fetch;
        end
    end

`ifndef SYNTHESIS
    a_fwd_only_in_rfwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fwd != '0) |-> (r_phase == ubce_pkg::PH_RFWD)) else $error("fwd outside read");
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == ubce_pkg::PH_IDLE) |-> (r_cnt == '0 && r_xor == '0))
        else $error("idle state dirty");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_job_full |-> !o_job_push) else $error("job pushed while full");
    a_no_write_under_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_buf_we |-> (r_fetch == '0)) else $error("buffer written under fetch");
`endif
endmodule
`default_nettype wire

### hdl/ubce_back.sv
// back end: expands jobs into result requests
`default_nettype none
module ubce_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire ubce_pkg::t_job  i_job,
    input  wire logic            i_job_empty,
    output logic                 o_job_pop,
    input  wire logic [7:0]      i_ack_byte,
    input  wire logic [7:0]      i_nack_byte,
    output logic                 o_buf_re,
    output logic [7:0]           o_buf_raddr,
    input  wire logic [7:0]      i_buf_rdata,
    output logic                 o_empty,
    input  wire logic            i_pop,
    output logic [2:0]           o_kind,
    output logic [7:0]           o_out_byte,
    output logic [31:0]          o_flash_address,
    output logic [8:0]           o_byte_count,
    output logic                 o_last
);
    logic [3:0] r_step, n_step;
    logic       r_wait, n_wait;
    logic       r_valid;
    logic [2:0] r_kind;
    logic [7:0] r_byte;
    logic [31:0] r_addr;
    logic [8:0] r_cnt;
    logic       r_last;
    logic       slot, emit, fin, raw;
    logic [2:0] e_kind;
    logic [7:0] e_byte;
    logic [31:0] e_addr;
    logic [8:0] e_cnt;

    assign slot = !r_valid || i_pop;
    assign o_buf_raddr = i_job.data;

    always_comb begin
        e_kind = ubce_pkg::K_TX; e_byte = '0; e_addr = '0; e_cnt = '0;
        fin = 1'b1; raw = 1'b0;
        case (i_job.kind)
            ubce_pkg::J_ACK: e_byte = i_ack_byte;
            ubce_pkg::J_NACK: e_byte = i_nack_byte;
            ubce_pkg::J_BYTE: e_byte = i_job.data;
            ubce_pkg::J_INFO: begin
                fin = (r_step == 4'd14);
                if (r_step == 4'd0 || fin) e_byte = i_ack_byte;
                else e_byte = ubce_pkg::info_byte(r_step - 4'd1);
            end
            ubce_pkg::J_VERSION: begin
                fin = (r_step == 4'd4);
                if (r_step == 4'd0 || fin) e_byte = i_ack_byte;
                else e_byte = ubce_pkg::version_byte(r_step - 4'd1);
            end
            ubce_pkg::J_READ: begin
                fin = (r_step == 4'd1);
                if (r_step == 4'd0) e_byte = i_ack_byte;
                else begin
                    e_kind = ubce_pkg::K_READ; e_addr = i_job.addr; e_cnt = i_job.count;
                end
            end
            ubce_pkg::J_WRITE: begin
                fin = (r_step == 4'd2);
                if (r_step == 4'd0) begin
                    e_kind = ubce_pkg::K_WRITE; e_addr = i_job.addr; e_cnt = i_job.count;
                end else if (r_step == 4'd1) e_byte = i_ack_byte;
                else begin
                    e_kind = ubce_pkg::K_NOTICE; e_addr = i_job.addr;
                end
            end
            ubce_pkg::J_ERASE: begin
                fin = (r_step == 4'd2);
                if (r_step == 4'd0) e_kind = ubce_pkg::K_ERASE;
                else if (r_step == 4'd2) e_kind = ubce_pkg::K_NOTICE;
                else e_byte = i_ack_byte;
            end
            ubce_pkg::J_BUF: begin
                e_kind = ubce_pkg::K_BUF; e_byte = i_buf_rdata; raw = 1'b1;
            end
            default: ;
        endcase
    end

    // buffer jobs read the ram first, then emit once the read data is in and the output slot is free
    assign o_buf_re = !i_job_empty && raw && !r_wait;
    assign emit = !i_job_empty && slot && (!raw || r_wait);
    assign o_job_pop = emit && fin;

    always_comb begin
        n_step = r_step; n_wait = r_wait;
        if (o_buf_re) n_wait = 1'b1;
        if (emit) begin
            n_step = fin ? 4'd0 : r_step + 4'd1;
            n_wait = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_kind <= e_kind; r_byte <= e_byte; r_addr <= e_addr;
            r_cnt <= e_cnt; r_last <= fin;
        end
        if (!i_rst_n) begin
            r_step <= '0; r_wait <= 1'b0; r_valid <= 1'b0;
        end else begin
            r_step <= n_step; r_wait <= n_wait;
            if (emit) r_valid <= 1'b1;
            else if (i_pop) r_valid <= 1'b0;
        end
    end

    assign o_empty = !r_valid;
    assign o_kind = r_kind;
    assign o_out_byte = r_byte;
    assign o_flash_address = r_addr;
    assign o_byte_count = r_cnt;
    assign o_last = r_last;

`ifndef SYNTHESIS
    a_pop_needs_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_pop |-> emit) else $error("pop without emit");
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= 4'd14) else $error("step out of range");
    a_wait_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wait |-> !i_job_empty) else $error("wait without job");
`endif
endmodule
`default_nettype wire

### hdl/uart_bootloader_command_engine.sv
// top level of the serial bootloader command engine
// channel   | direction | handshake     | payload
// input     | in        | push / full   | opcode, data_byte, fetch_index
// result    | out       | pop / empty   | kind, out_byte, flash_address, byte_count, last
// config    | in        | apb write     | timeout_ticks, ack_byte, nack_byte
// front end takes one request per cycle while the job queue has room and no pending fetch holds a buffer write
// buffer writes wait until queued fetches have read the buffer
// back end emits one result per cycle while the output slot is free; an info job expands into 15 results
// a buffer fetch reads the registered ram before its result is emitted
// reset is synchronous and clears control state and config to defaults
// the output register and job queue let either side stall on its own
`default_nettype none
module uart_bootloader_command_engine (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    output logic             o_full,
    input  wire logic [1:0]  i_opcode,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic [7:0]  i_fetch_index,
    output logic             o_empty,
    input  wire logic        i_pop,
    output logic [2:0]       o_kind,
    output logic [7:0]       o_out_byte,
    output logic [31:0]      o_flash_address,
    output logic [8:0]       o_byte_count,
    output logic             o_last,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    logic [15:0] r_timeout;
    logic [7:0]  r_ack, r_nack;
    logic        job_push, job_full, job_pop, job_empty, fetch_done;
    ubce_pkg::t_job job_in, job_out;
    logic        buf_we, buf_re;
    logic [7:0]  buf_waddr, buf_wdata, buf_raddr, buf_rdata;

    assign pready = 1'b1;
    assign fetch_done = job_pop && (job_out.kind == ubce_pkg::J_BUF);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= 16'd1000; r_ack <= 8'd121; r_nack <= 8'd31;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                ubce_pkg::R_TIMEOUT: r_timeout <= pwdata[15:0];
                ubce_pkg::R_ACK: r_ack <= pwdata[7:0];
                ubce_pkg::R_NACK: r_nack <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            ubce_pkg::R_TIMEOUT: prdata = {16'd0, r_timeout};
            ubce_pkg::R_ACK: prdata = {24'd0, r_ack};
            ubce_pkg::R_NACK: prdata = {24'd0, r_nack};
            default: prdata = '0;
        endcase
    end

    ubce_front u_front (
        .i_clk, .i_rst_n, .i_push, .o_full, .i_opcode, .i_data_byte, .i_fetch_index,
        .i_timeout_ticks(r_timeout), .o_job_push(job_push), .o_job(job_in),
        .i_job_full(job_full), .i_fetch_done(fetch_done), .o_buf_we(buf_we),
        .o_buf_waddr(buf_waddr), .o_buf_wdata(buf_wdata)
    );

    ubce_queue u_queue (
        .i_clk, .i_rst_n, .i_push(job_push), .i_job(job_in), .o_full(job_full),
        .i_pop(job_pop), .o_job(job_out), .o_empty(job_empty)
    );

    ubce_ram #(.Width(8), .Depth(ubce_pkg::BufDepth)) u_ram (
        .i_clk, .i_we(buf_we), .i_waddr(buf_waddr), .i_wdata(buf_wdata),
        .i_re(buf_re), .i_raddr(buf_raddr), .o_rdata(buf_rdata)
    );

    ubce_back u_back (
        .i_clk, .i_rst_n, .i_job(job_out), .i_job_empty(job_empty), .o_job_pop(job_pop),
        .i_ack_byte(r_ack), .i_nack_byte(r_nack), .o_buf_re(buf_re),
        .o_buf_raddr(buf_raddr), .i_buf_rdata(buf_rdata), .o_empty, .i_pop,
        .o_kind, .o_out_byte, .o_flash_address, .o_byte_count, .o_last
    );
endmodule
`default_nettype wire

### sim/tb_uart_bootloader_command_engine.sv
// self-checking testbench for the serial bootloader command engine
`default_nettype none
module tb_uart_bootloader_command_engine;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] data;
        logic [7:0] idx;
    } t_req;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  data;
        logic [31:0] addr;
        logic [8:0]  count;
        logic        last;
    } t_reply;

    localparam logic [7:0] INFO_BYTES [13] = '{8'd11, 8'h10, 8'h00, 8'h01, 8'h02, 8'h11,
                                               8'h21, 8'h31, 8'h43, 8'h63, 8'h73, 8'h82,
                                               8'h92};
    localparam logic [7:0] VERSION_BYTES [3] = '{8'h01, 8'h04, 8'h10};

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_push = 1'b0;
    logic [1:0]  i_opcode = ubce_pkg::OP_TICK;
    logic [7:0]  i_data_byte = 8'h00;
    logic [7:0]  i_fetch_index = 8'h00;
    logic        i_pop = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = 4'h0;
    logic [31:0] pwdata = 32'h0;
    logic        o_full, o_empty, o_last, pready;
    logic [2:0]  o_kind;
    logic [7:0]  o_out_byte;
    logic [31:0] o_flash_address, prdata;
    logic [8:0]  o_byte_count;

    uart_bootloader_command_engine u_top (.*);

    always #5 i_clk = ~i_clk;

    // predictor state
    ubce_pkg::t_phase phase = ubce_pkg::PH_IDLE;
    logic [7:0]  cmd = 8'h00;
    logic [31:0] addr_r = 32'h0;
    logic [8:0]  fcnt = 9'h0;
    logic [7:0]  len = 8'h00;
    logic [7:0]  xsum = 8'h00;
    logic [15:0] idle_ticks = 16'h0;
    logic [8:0]  fwd_left = 9'h0;
    logic [7:0]  page_buf [256];
    bit          page_ok [256];
    logic [15:0] cfg_timeout = 16'd1000;
    logic [7:0]  cfg_ack = 8'd121;
    logic [7:0]  cfg_nack = 8'd31;

    t_reply      step_res [15];
    int          step_n;
    t_req        pend_q [$];
    t_reply      due_q [$];
    int          errors = 0;
    int          checked = 0;
    int          accepted_cnt = 0;
    int          cyc = 0;
    logic        hold_go = 1'b0;
    logic        hold_done = 1'b0;
    int          hold_left = 0;
    wire         calm = (cyc >= 150) && (cyc < 350);

    function automatic void emit(logic [2:0] k, logic [7:0] b, logic [31:0] a, logic [8:0] c);
        if (step_n < 15) begin
            step_res[step_n] = '{k, b, a, c, 1'b0};
            step_n++;
        end
    endfunction

    function automatic void send(logic [7:0] b);
        emit(ubce_pkg::K_TX, b, 32'h0, 9'h0);
    endfunction

    function automatic void close_frame();
        phase = ubce_pkg::PH_IDLE;
        fcnt = 9'h0;
        xsum = 8'h00;
        idle_ticks = 16'h0;
        fwd_left = 9'h0;
    endfunction

    function automatic void second_byte(logic [7:0] b);
        logic known;
        known = cmd inside {ubce_pkg::C_INFO, ubce_pkg::C_VER, ubce_pkg::C_READ,
                            ubce_pkg::C_ERASE, ubce_pkg::C_WRITE, ubce_pkg::C_XERASE,
                            ubce_pkg::C_SPEC};
        if (!known || b != ~cmd) begin
            send(cfg_nack);
            close_frame();
            return;
        end
        send(cfg_ack);
        close_frame();
        case (cmd)
            ubce_pkg::C_INFO: begin
                for (int i = 0; i < 13; i++) send(INFO_BYTES[i]);
                send(cfg_ack);
            end
            ubce_pkg::C_VER: begin
                for (int i = 0; i < 3; i++) send(VERSION_BYTES[i]);
                send(cfg_ack);
            end
            ubce_pkg::C_READ, ubce_pkg::C_WRITE, ubce_pkg::C_SPEC: begin
                addr_r = 32'h0;
                fcnt = 9'h0;
                xsum = 8'h00;
                phase = ubce_pkg::PH_ADDR;
            end
            ubce_pkg::C_ERASE: phase = ubce_pkg::PH_ECNT;
            default: ;
        endcase
    endfunction

    function automatic void take_byte(logic [7:0] b);
        idle_ticks = 16'h0;
        case (phase)
            ubce_pkg::PH_IDLE: begin
                if (b == ubce_pkg::C_SYNC) send(cfg_ack);
                else begin
                    cmd = b;
                    phase = ubce_pkg::PH_CMD2;
                end
            end
            ubce_pkg::PH_CMD2: second_byte(b);
            ubce_pkg::PH_ADDR: begin
                addr_r = {addr_r[23:0], b};
                xsum ^= b;
                fcnt++;
                if (fcnt >= ((cmd == ubce_pkg::C_SPEC) ? 9'd2 : 9'd4))
                    phase = ubce_pkg::PH_ADDR_X;
            end
            ubce_pkg::PH_ADDR_X: begin
                if (xsum != b) begin
                    send(cfg_nack);
                    close_frame();
                end else begin
                    send(cfg_ack);
                    if (cmd == ubce_pkg::C_READ) phase = ubce_pkg::PH_RCNT;
                    else if (cmd == ubce_pkg::C_WRITE) phase = ubce_pkg::PH_WCNT;
                    else close_frame();
                end
            end
            ubce_pkg::PH_RCNT: begin
                len = b;
                phase = ubce_pkg::PH_RCNT_X;
            end
            ubce_pkg::PH_RCNT_X: begin
                if ((8'hFF ^ len) != b) begin
                    send(cfg_nack);
                    close_frame();
                end else begin
                    send(cfg_ack);
                    emit(ubce_pkg::K_READ, 8'h00, addr_r, {1'b0, len} + 9'd1);
                    fcnt = 9'h0;
                    fwd_left = {1'b0, len} + 9'd1;
                    phase = ubce_pkg::PH_RFWD;
                end
            end
            ubce_pkg::PH_ECNT: begin
                if (b == 8'hFF) phase = ubce_pkg::PH_EX;
                else begin
                    send(cfg_nack);
                    close_frame();
                end
            end
            ubce_pkg::PH_EX: begin
                emit(ubce_pkg::K_ERASE, 8'h00, 32'h0, 9'h0);
                send(cfg_ack);
                emit(ubce_pkg::K_NOTICE, 8'h00, 32'h0, 9'h0);
                close_frame();
            end
            ubce_pkg::PH_WCNT: begin
                len = b;
                xsum = b;
                fcnt = 9'h0;
                phase = ubce_pkg::PH_WDATA;
            end
            ubce_pkg::PH_WDATA: begin
                page_buf[fcnt[7:0]] = b;
                page_ok[fcnt[7:0]] = 1'b1;
                xsum ^= b;
                fcnt++;
                if (fcnt >= {1'b0, len} + 9'd1) phase = ubce_pkg::PH_WDATA_X;
            end
            ubce_pkg::PH_WDATA_X: begin
                if (xsum != b) send(cfg_nack);
                else begin
                    emit(ubce_pkg::K_WRITE, 8'h00, addr_r, {1'b0, len} + 9'd1);
                    send(cfg_ack);
                    emit(ubce_pkg::K_NOTICE, 8'h00, addr_r, 9'h0);
                end
                close_frame();
            end
            ubce_pkg::PH_RFWD: ;
            default: close_frame();
        endcase
    endfunction

    function automatic void bootloader_step(t_req r);
        step_n = 0;
        case (r.op)
            ubce_pkg::OP_RX: take_byte(r.data);
            ubce_pkg::OP_TICK: begin
                if (phase == ubce_pkg::PH_IDLE) idle_ticks = 16'h0;
                else begin
                    if (idle_ticks != 16'hFFFF) idle_ticks++;
                    if (idle_ticks >= cfg_timeout) begin
                        if (phase == ubce_pkg::PH_CMD2) send(cfg_nack);
                        close_frame();
                    end
                end
            end
            ubce_pkg::OP_FLASH: begin
                if (phase == ubce_pkg::PH_RFWD && fwd_left != 9'h0) begin
                    idle_ticks = 16'h0;
                    page_buf[fcnt[7:0]] = r.data;
                    page_ok[fcnt[7:0]] = 1'b1;
                    send(r.data);
                    fcnt++;
                    fwd_left--;
                    if (fwd_left == 9'h0) close_frame();
                end
            end
            default: emit(ubce_pkg::K_BUF, page_buf[r.idx], 32'h0, 9'h0);
        endcase
        if (step_n > 0) step_res[step_n - 1].last = 1'b1;
        for (int i = 0; i < step_n; i++) due_q.push_back(step_res[i]);
    endfunction

    // never fetch an entry that was never written
    function automatic t_req fix_fetch(t_req r);
        int start;
        if (r.op != ubce_pkg::OP_FETCH || page_ok[r.idx]) return r;
        start = $urandom_range(255);
        for (int i = 0; i < 256; i++) begin
            if (page_ok[(start + i) % 256]) begin
                r.idx = 8'((start + i) % 256);
                return r;
            end
        end
        r.op = ubce_pkg::OP_TICK;
        return r;
    endfunction

    // request driver
    always @(posedge i_clk) begin
        t_req nxt;
        logic push_n;
        cyc <= cyc + 1;
        if (i_rst_n) begin
            push_n = i_push;
            nxt = '{i_opcode, i_data_byte, i_fetch_index};
            if (i_push && !o_full) begin
                bootloader_step(nxt);
                accepted_cnt++;
            end
            if (!i_push || !o_full) begin
                if (pend_q.size() != 0 && (calm || $urandom_range(99) >= 28)) begin
                    nxt = fix_fetch(pend_q.pop_front());
                    push_n = 1'b1;
                end else begin
                    push_n = 1'b0;
                end
            end
            i_push <= push_n;
            i_opcode <= nxt.op;
            i_data_byte <= nxt.data;
            i_fetch_index <= nxt.idx;
        end
    end

    // result side: random pops plus one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_pop <= 1'b0;
        end else if (hold_go && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= 400;
            i_pop <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_pop <= 1'b0;
        end else begin
            i_pop <= calm || ($urandom_range(99) >= 28);
        end
    end

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %0s: got %0h want %0h at cycle %0d", what, got, want, cyc);
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_reply w;
        if (i_rst_n && i_pop && !o_empty) begin
            if (due_q.size() == 0) begin
                report("unexpected result kind", 32'(o_kind), 32'h0);
            end else begin
                w = due_q.pop_front();
                checked++;
                if (o_kind != w.kind) report("kind", 32'(o_kind), 32'(w.kind));
                if (o_out_byte != w.data) report("out_byte", 32'(o_out_byte), 32'(w.data));
                if (o_flash_address != w.addr) report("flash_address", o_flash_address, w.addr);
                if (o_byte_count != w.count) report("byte_count", 32'(o_byte_count), 32'(w.count));
                if (o_last != w.last) report("last", 32'(o_last), 32'(w.last));
            end
        end
    end

    task automatic reg_write(logic [1:0] idx, logic [31:0] v);
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic configure(logic [15:0] tmo, logic [7:0] ack, logic [7:0] nack);
        reg_write(ubce_pkg::R_TIMEOUT, 32'(tmo));
        reg_write(ubce_pkg::R_ACK, 32'(ack));
        reg_write(ubce_pkg::R_NACK, 32'(nack));
        cfg_timeout = tmo;
        cfg_ack = ack;
        cfg_nack = nack;
    endtask

    task automatic drain();
        while (pend_q.size() != 0 || i_push || due_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    function automatic void put(logic [1:0] op, logic [7:0] b, logic [7:0] idx);
        pend_q.push_back('{op, b, idx});
    endfunction

    function automatic void put_rx(logic [7:0] b);
        put(ubce_pkg::OP_RX, b, 8'h00);
    endfunction

    function automatic void put_pair(logic [7:0] c);
        put_rx(c);
        put_rx(~c);
    endfunction

    function automatic void put_addr(logic [31:0] a, int nbytes, bit bad);
        logic [7:0] x;
        x = 8'h00;
        for (int i = nbytes - 1; i >= 0; i--) begin
            put_rx(a[8*i +: 8]);
            x ^= a[8*i +: 8];
        end
        put_rx(bad ? ~x : x);
    endfunction

    function automatic void seq_read(logic [31:0] a, logic [7:0] n, bit bad_addr, bit bad_cnt);
        put_pair(ubce_pkg::C_READ);
        put_addr(a, 4, bad_addr);
        if (bad_addr) return;
        put_rx(n);
        put_rx(bad_cnt ? n : ~n);
        if (bad_cnt) return;
        for (int i = 0; i <= n; i++) begin
            if ($urandom_range(9) == 0) put_rx(8'($urandom));
            put(ubce_pkg::OP_FLASH, 8'($urandom), 8'h00);
        end
        put(ubce_pkg::OP_FLASH, 8'($urandom), 8'h00);
    endfunction

    function automatic void seq_write(logic [31:0] a, logic [7:0] n, bit bad);
        logic [7:0] x;
        logic [7:0] d;
        x = n;
        put_pair(ubce_pkg::C_WRITE);
        put_addr(a, 4, 1'b0);
        put_rx(n);
        for (int i = 0; i <= n; i++) begin
            d = 8'($urandom);
            x ^= d;
            put_rx(d);
        end
        put_rx(bad ? ~x : x);
    endfunction

    function automatic void seq_erase(bit page);
        put_pair(ubce_pkg::C_ERASE);
        put_rx(page ? 8'($urandom_range(254)) : 8'hFF);
        if (!page) put_rx(8'($urandom));
    endfunction

    function automatic void seq_fetches(int cnt);
        for (int i = 0; i < cnt; i++) put(ubce_pkg::OP_FETCH, 8'h00, 8'($urandom));
    endfunction

    function automatic void seq_random(int cnt, int tmo);
        int sel;
        int start;
        start = pend_q.size();
        while (pend_q.size() - start < cnt) begin
            sel = $urandom_range(11);
            case (sel)
                0: put_rx(ubce_pkg::C_SYNC);
                1: put_pair(ubce_pkg::C_INFO);
                2: put_pair($urandom_range(1) ? ubce_pkg::C_VER : ubce_pkg::C_XERASE);
                3, 4: seq_read($urandom, 8'($urandom_range(6)), $urandom_range(5) == 0,
                               $urandom_range(5) == 0);
                5, 6: seq_write($urandom, 8'($urandom_range(6)), $urandom_range(4) == 0);
                7: seq_erase($urandom_range(3) == 0);
                8: begin
                    put_pair(ubce_pkg::C_SPEC);
                    put_addr($urandom, 2, $urandom_range(2) == 0);
                end
                9: seq_fetches(3);
                10: begin
                    put_rx(8'($urandom));
                    if (tmo <= 8) for (int i = 0; i < tmo; i++)
                        put(ubce_pkg::OP_TICK, 8'h00, 8'h00);
                end
                default: put(2'($urandom), 8'($urandom), 8'($urandom));
            endcase
        end
    endfunction

    initial begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        for (int i = 0; i < 256; i++) begin
            page_buf[i] = 8'h00;
            page_ok[i] = 1'b0;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed requests at reset settings
        put_rx(ubce_pkg::C_SYNC);
        put_pair(ubce_pkg::C_INFO);
        put_pair(ubce_pkg::C_VER);
        put_pair(ubce_pkg::C_XERASE);
        put_rx(8'h12);
        put_rx(8'h34);
        put_pair(8'h12);
        seq_read(32'hFFFF_FFFF, 8'h00, 1'b0, 1'b0);
        seq_fetches(1);
        seq_write(32'h0000_0000, 8'h01, 1'b0);
        seq_erase(1'b0);
        seq_erase(1'b1);
        put_pair(ubce_pkg::C_SPEC);
        put_addr(32'h0000_A55A, 2, 1'b0);
        drain();

        // shortest timeout: second-byte timeout and silent abort
        configure(16'd1, 8'h00, 8'hFF);
        put_rx(ubce_pkg::C_READ);
        put(ubce_pkg::OP_TICK, 8'h00, 8'h00);
        put_pair(ubce_pkg::C_READ);
        put_rx(8'h01);
        put(ubce_pkg::OP_TICK, 8'h00, 8'h00);
        put(ubce_pkg::OP_FLASH, 8'hAA, 8'h00);
        seq_random(10, 1);
        drain();

        configure(16'hFFFF, 8'hFF, 8'h00);
        seq_write(32'h8000_0001, 8'h1F, 1'b0);
        put(ubce_pkg::OP_FETCH, 8'h00, 8'h00);
        put(ubce_pkg::OP_FETCH, 8'h00, 8'h1F);
        hold_go <= 1'b1;
        seq_random(10, 65535);
        drain();

        configure(16'd4, 8'h79, 8'h1F);
        seq_read(32'h0123_4567, 8'h0F, 1'b0, 1'b0);
        seq_random(10, 4);
        drain();

        $display("requests accepted: %0d, results checked: %0d, mismatches: %0d",
                 accepted_cnt, checked, errors);
        $display("covered all commands, checksum errors, timeouts and four register settings");
        if (errors == 0 && due_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire
